/* hw/rtl/trs_pkg.sv */
// Package for the TRS model matrix builder: widths, CORDIC constants,
// shared types and fixed-point helper functions. Depends on nothing.
package trs_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int CORDIC_STEPS  = 16;
  localparam int Q30_W         = 32;
  localparam int ROT_W         = 33;
  localparam int Z_W           = 25;

  localparam logic signed [Q30_W-1:0] CORDIC_ONE_GAIN = 32'sd652032874;

  typedef logic signed [15:0]      fix16_t;
  typedef logic signed [Q30_W-1:0] q30_t;
  typedef logic signed [ROT_W-1:0] rot_e_t;
  typedef logic signed [Z_W-1:0]   zres_t;

  // Scale and shift fields that ride alongside the angle pipeline.
  typedef struct packed {
    fix16_t scale_x;
    fix16_t scale_y;
    fix16_t scale_z;
    fix16_t shift_x;
    fix16_t shift_y;
    fix16_t shift_z;
  } side_t;

  // Arctangent of 2^-k in units of 1/65536 degree.
  function automatic zres_t atan_step(input int k);
    zres_t a;
    unique case (k)
      0:  a = 25'sd2949120;
      1:  a = 25'sd1740967;
      2:  a = 25'sd919879;
      3:  a = 25'sd466945;
      4:  a = 25'sd234379;
      5:  a = 25'sd117306;
      6:  a = 25'sd58666;
      7:  a = 25'sd29335;
      8:  a = 25'sd14668;
      9:  a = 25'sd7334;
      10: a = 25'sd3667;
      11: a = 25'sd1833;
      12: a = 25'sd917;
      13: a = 25'sd458;
      14: a = 25'sd229;
      default: a = 25'sd115;
    endcase
    return a;
  endfunction

  // Product of two Q1.30 values, rounded half up back to Q1.30.
  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

  // Rotation entry (Q.30) times a scale factor, rounded and saturated.
  function automatic fix16_t scale_sat(input rot_e_t r, input fix16_t s);
    logic signed [48:0] p;
    logic signed [18:0] q;
    p = 49'(r) * 49'(s) + 49'sd536870912;
    q = p[48:30];
    if (q > 19'sd32767) begin
      return 16'sh7fff;
    end else if (q < -19'sd32768) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

endpackage

/* hw/rtl/trs_if.sv */
// Valid/ready channel interfaces for the pose input and the row output.
// Depend on trs_pkg for the field types.
interface trs_in_if;
  logic            valid;
  logic            ready;
  trs_pkg::fix16_t scale_x;
  trs_pkg::fix16_t scale_y;
  trs_pkg::fix16_t scale_z;
  trs_pkg::fix16_t yaw_angle;
  trs_pkg::fix16_t pitch_angle;
  trs_pkg::fix16_t roll_angle;
  trs_pkg::fix16_t shift_x;
  trs_pkg::fix16_t shift_y;
  trs_pkg::fix16_t shift_z;

  modport source (output valid, scale_x, scale_y, scale_z, yaw_angle, pitch_angle,
                  roll_angle, shift_x, shift_y, shift_z, input ready);
  modport sink (input valid, scale_x, scale_y, scale_z, yaw_angle, pitch_angle,
                roll_angle, shift_x, shift_y, shift_z, output ready);
endinterface

interface trs_out_if;
  logic            valid;
  logic            ready;
  logic [1:0]      row_index;
  trs_pkg::fix16_t col0;
  trs_pkg::fix16_t col1;
  trs_pkg::fix16_t col2;
  trs_pkg::fix16_t col3;
  logic            last_row;

  modport source (output valid, row_index, col0, col1, col2, col3, last_row,
                  input ready);
  modport sink (input valid, row_index, col0, col1, col2, col3, last_row,
                output ready);
endinterface

/* hw/rtl/trs_cordic.sv */
// Angle reduction and three parallel pipelined rotation-mode CORDIC lanes
// (yaw, pitch, roll), one step per stage. Depends on trs_pkg.
module trs_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  trs_pkg::fix16_t     angle_i [3],
  input  trs_pkg::side_t      side_i,
  output logic                out_valid,
  output trs_pkg::q30_t       sin_o [3],
  output trs_pkg::q30_t       cos_o [3],
  output trs_pkg::side_t      side_o
);

  localparam int N = trs_pkg::CORDIC_STEPS;

  typedef struct packed {
    logic                neg;
    trs_pkg::zres_t      z;
  } fold_t;

  // Reduce to (-180, 180] degrees, then fold into [-90, 90] negating cosine.
  function automatic fold_t fold_angle(input trs_pkg::fix16_t a);
    logic signed [17:0] r;
    fold_t f;
    r = {{2{a[15]}}, a};
    if (r >= 18'sd23040) begin
      r = r - 18'sd23040;
    end else if (r <= -18'sd23040) begin
      r = r + 18'sd23040;
    end
    if (r < 18'sd0) begin
      r = r + 18'sd23040;
    end
    if (r > 18'sd11520) begin
      r = r - 18'sd23040;
    end
    f.neg = 1'b0;
    if (r > 18'sd5760) begin
      r = 18'sd11520 - r;
      f.neg = 1'b1;
    end else if (r < -18'sd5760) begin
      r = -18'sd11520 - r;
      f.neg = 1'b1;
    end
    f.z = {r[14:0], 10'b0};
    return f;
  endfunction

  trs_pkg::q30_t  x_r [N+1][3];
  trs_pkg::q30_t  y_r [N+1][3];
  trs_pkg::zres_t z_r [N+1][3];
  logic           neg_r [N+1][3];
  trs_pkg::side_t side_r [N+1];
  logic [N:0]     vld_r;
  fold_t          fold_w [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      fold_w[l] = fold_angle(angle_i[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int l = 0; l < 3; l++) begin
        x_r[0][l]   <= trs_pkg::CORDIC_ONE_GAIN;
        y_r[0][l]   <= '0;
        z_r[0][l]   <= fold_w[l].z;
        neg_r[0][l] <= fold_w[l].neg;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
        for (int l = 0; l < 3; l++) begin
          neg_r[k+1][l] <= neg_r[k][l];
          if (z_r[k][l] >= 0) begin
            x_r[k+1][l] <= x_r[k][l] - (y_r[k][l] >>> k);
            y_r[k+1][l] <= y_r[k][l] + (x_r[k][l] >>> k);
            z_r[k+1][l] <= z_r[k][l] - trs_pkg::atan_step(k);
          end else begin
            x_r[k+1][l] <= x_r[k][l] + (y_r[k][l] >>> k);
            y_r[k+1][l] <= y_r[k][l] - (x_r[k][l] >>> k);
            z_r[k+1][l] <= z_r[k][l] + trs_pkg::atan_step(k);
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sin_o[l] = y_r[N][l];
      cos_o[l] = neg_r[N][l] ? -x_r[N][l] : x_r[N][l];
    end
  end

  assign out_valid = vld_r[N];
  assign side_o    = side_r[N];

endmodule

/* hw/rtl/trs_rotmat.sv */
// Two pipeline stages of Q1.30 products that build the 3x3 rotation
// Rz*Ry*Rx from sines and cosines. Depends on trs_pkg.
module trs_rotmat (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  trs_pkg::q30_t    sin_i [3],
  input  trs_pkg::q30_t    cos_i [3],
  input  trs_pkg::side_t   side_i,
  output logic             out_valid,
  output trs_pkg::rot_e_t  rot_o [9],
  output trs_pkg::side_t   side_o
);

  // First stage: the products of two angle terms that the second stage uses.
  trs_pkg::q30_t spsr_r, spcr_r, cycp_r, sycr_r, sysr_r, sycp_r;
  trs_pkg::q30_t cycr_r, cysr_r, cpsr_r, cpcr_r, cy_r, sy_r, sp_r;
  trs_pkg::side_t side1_r;
  logic v1_r, v2_r;

  trs_pkg::rot_e_t rot_r [9];
  trs_pkg::side_t  side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spsr_r  <= trs_pkg::mul_q30(sin_i[1], sin_i[2]);
      spcr_r  <= trs_pkg::mul_q30(sin_i[1], cos_i[2]);
      cycp_r  <= trs_pkg::mul_q30(cos_i[0], cos_i[1]);
      sycr_r  <= trs_pkg::mul_q30(sin_i[0], cos_i[2]);
      sysr_r  <= trs_pkg::mul_q30(sin_i[0], sin_i[2]);
      sycp_r  <= trs_pkg::mul_q30(sin_i[0], cos_i[1]);
      cycr_r  <= trs_pkg::mul_q30(cos_i[0], cos_i[2]);
      cysr_r  <= trs_pkg::mul_q30(cos_i[0], sin_i[2]);
      cpsr_r  <= trs_pkg::mul_q30(cos_i[1], sin_i[2]);
      cpcr_r  <= trs_pkg::mul_q30(cos_i[1], cos_i[2]);
      cy_r    <= cos_i[0];
      sy_r    <= sin_i[0];
      sp_r    <= sin_i[1];
      side1_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r[0] <= 33'(cycp_r);
      rot_r[1] <= 33'(trs_pkg::mul_q30(cy_r, spsr_r)) - 33'(sycr_r);
      rot_r[2] <= 33'(trs_pkg::mul_q30(cy_r, spcr_r)) + 33'(sysr_r);
      rot_r[3] <= 33'(sycp_r);
      rot_r[4] <= 33'(trs_pkg::mul_q30(sy_r, spsr_r)) + 33'(cycr_r);
      rot_r[5] <= 33'(trs_pkg::mul_q30(sy_r, spcr_r)) - 33'(cysr_r);
      rot_r[6] <= -33'(sp_r);
      rot_r[7] <= 33'(cpsr_r);
      rot_r[8] <= 33'(cpcr_r);
      side2_r  <= side1_r;
    end
  end

  assign out_valid = v2_r;
  assign rot_o     = rot_r;
  assign side_o    = side2_r;

endmodule

/* hw/rtl/trs_rowser.sv */
// Scales the rotation columns, saturates, holds the finished matrix and
// sends it as four row beats. Produces the pipeline advance. Depends on trs_pkg.
module trs_rowser #(
  parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  trs_pkg::rot_e_t  rot_i [9],
  input  trs_pkg::side_t   side_i,
  output logic             en,
  trs_out_if.source        out_ch
);

  localparam trs_pkg::fix16_t ONE_VAL =
    (FRAC_BITS >= 15) ? 16'sh7fff : 16'(1 << FRAC_BITS);

  trs_pkg::fix16_t ent_r [9];
  trs_pkg::fix16_t sh_r [3];
  logic            mv_r;
  logic [1:0]      row_r;

  // The hold register takes a new matrix when empty or as row 3 leaves.
  assign en = !mv_r || (out_ch.ready && (row_r == 2'd3));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r  <= 1'b0;
      row_r <= 2'd0;
    end else if (en) begin
      mv_r  <= in_valid;
      row_r <= 2'd0;
    end else if (out_ch.ready) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r[0] <= trs_pkg::scale_sat(rot_i[0], side_i.scale_x);
      ent_r[1] <= trs_pkg::scale_sat(rot_i[1], side_i.scale_y);
      ent_r[2] <= trs_pkg::scale_sat(rot_i[2], side_i.scale_z);
      ent_r[3] <= trs_pkg::scale_sat(rot_i[3], side_i.scale_x);
      ent_r[4] <= trs_pkg::scale_sat(rot_i[4], side_i.scale_y);
      ent_r[5] <= trs_pkg::scale_sat(rot_i[5], side_i.scale_z);
      ent_r[6] <= trs_pkg::scale_sat(rot_i[6], side_i.scale_x);
      ent_r[7] <= trs_pkg::scale_sat(rot_i[7], side_i.scale_y);
      ent_r[8] <= trs_pkg::scale_sat(rot_i[8], side_i.scale_z);
      sh_r[0]  <= side_i.shift_x;
      sh_r[1]  <= side_i.shift_y;
      sh_r[2]  <= side_i.shift_z;
    end
  end

  always_comb begin
    unique case (row_r)
      2'd0: begin
        out_ch.col0 = ent_r[0];
        out_ch.col1 = ent_r[1];
        out_ch.col2 = ent_r[2];
        out_ch.col3 = sh_r[0];
      end
      2'd1: begin
        out_ch.col0 = ent_r[3];
        out_ch.col1 = ent_r[4];
        out_ch.col2 = ent_r[5];
        out_ch.col3 = sh_r[1];
      end
      2'd2: begin
        out_ch.col0 = ent_r[6];
        out_ch.col1 = ent_r[7];
        out_ch.col2 = ent_r[8];
        out_ch.col3 = sh_r[2];
      end
      default: begin
        out_ch.col0 = '0;
        out_ch.col1 = '0;
        out_ch.col2 = '0;
        out_ch.col3 = ONE_VAL;
      end
    endcase
  end

  assign out_ch.valid     = mv_r;
  assign out_ch.row_index = row_r;
  assign out_ch.last_row  = (row_r == 2'd3);

endmodule

/* hw/rtl/trs_model_matrix_builder.sv */
// Top level of the TRS model matrix builder: CORDIC, rotation and row
// sender stages. Depends on trs_pkg, trs_if, trs_cordic, trs_rotmat, trs_rowser.
//
// Usage: each beat on in_ch carries one pose (three Q8.8 scale factors,
// yaw, pitch and roll in 1/64 degree, three Q8.8 offsets). The block forms
// M = T * Rz * Ry * Rx * S and sends it on out_ch as four row beats,
// row_index 0 to 3, with last_row set on row 3. Entries saturate to 16 bits.
// Path: an accepted pose reaches row 0 through one angle reduction stage,
// sixteen CORDIC stages, two product stages and the scaling stage that
// loads the output hold register.
// Flow: the output hold register sends four row beats for each matrix and
// takes the next matrix only as row 3 leaves; while the hold register is
// empty, poses may be accepted in consecutive cycles and queue in the pipeline.
// Stall: the whole pipeline advances only while the hold register can take
// a new matrix, so a stalled receiver freezes every stage in place. in_ch.ready
// follows that advance: it is low whenever the hold register holds a matrix,
// except in the cycle in which row 3 is taken.
// Reset: synchronous, active low rst_n clears all valid bits and the row
// counter; no pose is in flight afterwards.
module trs_model_matrix_builder #(
  parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  trs_in_if.sink    in_ch,
  trs_out_if.source out_ch
);

  logic             en;
  logic             cv, rv;
  trs_pkg::fix16_t  angles [3];
  trs_pkg::side_t   side_in, side_c, side_r;
  trs_pkg::q30_t    sin_w [3];
  trs_pkg::q30_t    cos_w [3];
  trs_pkg::rot_e_t  rot_w [9];

  assign in_ch.ready = en;

  assign angles[0] = in_ch.yaw_angle;
  assign angles[1] = in_ch.pitch_angle;
  assign angles[2] = in_ch.roll_angle;

  assign side_in = '{scale_x: in_ch.scale_x, scale_y: in_ch.scale_y,
                     scale_z: in_ch.scale_z, shift_x: in_ch.shift_x,
                     shift_y: in_ch.shift_y, shift_z: in_ch.shift_z};

  trs_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .angle_i   (angles),
    .side_i    (side_in),
    .out_valid (cv),
    .sin_o     (sin_w),
    .cos_o     (cos_w),
    .side_o    (side_c)
  );

  trs_rotmat u_rotmat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cv),
    .sin_i     (sin_w),
    .cos_i     (cos_w),
    .side_i    (side_c),
    .out_valid (rv),
    .rot_o     (rot_w),
    .side_o    (side_r)
  );

  trs_rowser #(.FRAC_BITS(FRAC_BITS)) u_rowser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rv),
    .rot_i    (rot_w),
    .side_i   (side_r),
    .en       (en),
    .out_ch   (out_ch)
  );

endmodule

/* hw/rtl/trs_checker.sv */
// Port-level checks for the TRS model matrix builder and their bind.
// Depends on the top level's output channel only.
module trs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  row_index,
  input logic [15:0] col0,
  input logic [15:0] col1,
  input logic [15:0] col2,
  input logic        last_row
);

  // The last flag marks row 3 and nothing else.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_row == (row_index == 2'd3)))
    else $error("last_row does not match row_index");

  // The bottom row of the matrix has zeros in the first three columns.
  a_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && row_index == 2'd3) |-> (col0 == '0 && col1 == '0 && col2 == '0))
    else $error("row 3 carries nonzero rotation entries");

  // A matrix's rows follow each other without a gap.
  a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && row_index != 2'd3) |=>
      (out_valid && row_index == $past(row_index) + 2'd1))
    else $error("row sequence broken");

  // A stalled beat holds its row.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(row_index) && $stable(col0)))
    else $error("stalled beat changed");

endmodule

bind trs_model_matrix_builder trs_checker u_trs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .row_index (out_ch.row_index),
  .col0      (out_ch.col0),
  .col1      (out_ch.col1),
  .col2      (out_ch.col2),
  .last_row  (out_ch.last_row)
);
